>>> sv/mmb_pkg.sv
// Package for the MMB block cipher core: types, constants, round helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mmb_pkg;
  localparam int unsigned RoundCount = 6;
  localparam int unsigned FinalShift = 6;
  localparam logic [31:0] WordMask = 32'hFFFF_FFFF;
  localparam logic [31:0] MmbDelta = 32'h2AAA_AAAA;

  typedef logic [3:0][31:0] block_t;

  // Register indexes of the key port.
  typedef enum logic [1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } key_idx_e;

  typedef struct packed {
    logic valid;
    logic mode;
  } stage_ctl_t;

  function automatic logic [31:0] mul_const(input logic inv, input logic [1:0] idx);
    logic [31:0] c;
    unique case ({inv, idx})
      3'd0: c = 32'h025F_1CDB;
      3'd1: c = 32'h04BE_39B6;
      3'd2: c = 32'h12F8_E6D8;
      3'd3: c = 32'h2F8E_6D81;
      3'd4: c = 32'h0DAD_4694;
      3'd5: c = 32'h06D6_A34A;
      3'd6: c = 32'h81B5_A8D2;
      default: c = 32'h281B_5A8D;
    endcase
    return c;
  endfunction

  function automatic block_t key_mix(input block_t w, input block_t k,
                                     input logic [1:0] shift);
    block_t r;
    for (int i = 0; i < 4; i++) begin
      r[i] = w[i] ^ k[2'(i) + shift];
    end
    return r;
  endfunction

  // Reduce a 64-bit product modulo 2^32-1; all-ones maps to zero.
  function automatic logic [31:0] mod_fold(input logic [63:0] p);
    logic [32:0] s;
    logic [31:0] t;
    s = {1'b0, p[63:32]} + {1'b0, p[31:0]};
    t = s[31:0] + {31'd0, s[32]};
    return (t == WordMask) ? 32'd0 : t;
  endfunction

  function automatic block_t delta_mix(input block_t w);
    block_t r;
    r = w;
    if (w[0][0]) r[0] = w[0] ^ MmbDelta;
    if (w[3][0]) r[3] = w[3] ^ MmbDelta;
    return r;
  endfunction

  function automatic block_t theta_mix(input block_t w);
    block_t r;
    r[0] = w[0] ^ w[1] ^ w[3];
    r[1] = w[0] ^ w[1] ^ w[2];
    r[2] = w[1] ^ w[2] ^ w[3];
    r[3] = w[0] ^ w[2] ^ w[3];
    return r;
  endfunction
endpackage
`default_nettype wire

>>> sv/mmb_round_cell.sv
// One round cell: two register stages (pre-multiply, post-multiply).
// Depends on mmb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmb_round_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [1:0]        enc_shift_i,
  input  wire logic [1:0]        dec_shift_i,
  input  wire mmb_pkg::block_t   key_i,
  input  wire mmb_pkg::stage_ctl_t ctl_i,
  input  wire mmb_pkg::block_t   data_i,
  output mmb_pkg::stage_ctl_t    ctl_o,
  output mmb_pkg::block_t        data_o
);
  import mmb_pkg::*;

  stage_ctl_t ctl_a_q, ctl_b_q;
  block_t     mul_in_d, mul_in_q, prod_res;
  logic [3:0][63:0] prod_d, prod_q;

  // Encrypt: key mix then multiply. Decrypt: theta, delta then multiply.
  always_comb begin
    if (ctl_i.mode) mul_in_d = delta_mix(theta_mix(data_i));
    else            mul_in_d = key_mix(data_i, key_i, enc_shift_i);
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = 64'(mul_in_q[i]) * 64'(mul_const(ctl_a_q.mode, 2'(i)));
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_res[i] = (prod_q[i] == 64'hFFFF_FFFF_0000_0000) ? WordMask :
                    mod_fold(prod_q[i]);
    end
  end

  // All-ones passes through: flag via product marker (w*c never yields this value).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_in_q <= mul_in_d;
      for (int i = 0; i < 4; i++) begin
        prod_q[i] <= (mul_in_q[i] == WordMask) ? 64'hFFFF_FFFF_0000_0000 : prod_d[i];
      end
    end
  end

  always_comb begin
    if (ctl_b_q.mode) data_o = key_mix(prod_res, key_i, dec_shift_i);
    else              data_o = theta_mix(delta_mix(prod_res));
  end

  assign ctl_o = ctl_b_q;
endmodule
`default_nettype wire

>>> sv/mmb_block_cipher_core.sv
// MMB block cipher core: key registers, chain of round cells, end key mixes.
// Depends on mmb_pkg and mmb_round_cell.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries mode and four words; the
//  output channel (out_valid_o / out_stall_i) carries the four result words.
//  Key words (cfg port, index 0..3): user writes only while idle; not enforced.
//  The datapath is a chain of six round cells, each two register stages
//  (one 32x32 multiply per lane per cell), plus an input and output register.
//  Throughput: one block per cycle when not stalled; blocks are independent.
//  The whole chain advances together; when the output is stalled holding a
//  result, the chain freezes and in_stall_o is raised, otherwise a new block
//  is taken every cycle.
//  Reset clears all valid flags and the key registers to zero.
//  Encrypt cell r applies key rotation r; decrypt runs cells in reverse
//  rotation order, with the rotation-6 key mix done on input.
module mmb_block_cipher_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [31:0] in_word0_i,
  input  wire logic [31:0] in_word1_i,
  input  wire logic [31:0] in_word2_i,
  input  wire logic [31:0] in_word3_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      out_word0_o,
  output logic [31:0]      out_word1_o,
  output logic [31:0]      out_word2_o,
  output logic [31:0]      out_word3_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import mmb_pkg::*;

  block_t     key_q;
  logic       en;
  stage_ctl_t ctl_in_q, ctl_out_q;
  block_t     data_in_q, data_out_q, in_blk, in_d, out_d;
  stage_ctl_t ctl_c [RoundCount+1];
  block_t     data_c [RoundCount+1];

  assign cfg_ready_o = 1'b1;
  assign en = !(ctl_out_q.valid && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (key_idx_e'(cfg_index_i))
        KEY_WORD0: key_q[0] <= cfg_data_i;
        KEY_WORD1: key_q[1] <= cfg_data_i;
        KEY_WORD2: key_q[2] <= cfg_data_i;
        KEY_WORD3: key_q[3] <= cfg_data_i;
        default:   key_q[0] <= key_q[0];
      endcase
    end
  end

  assign in_blk = {in_word3_i, in_word2_i, in_word1_i, in_word0_i};
  assign in_d = mode_i ? key_mix(in_blk, key_q, 2'(FinalShift)) : in_blk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_in_q  <= '0;
      ctl_out_q <= '0;
    end else if (en) begin
      ctl_in_q  <= '{valid: in_valid_i, mode: mode_i};
      ctl_out_q <= ctl_c[RoundCount];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_in_q  <= in_d;
      data_out_q <= out_d;
    end
  end

  assign ctl_c[0]  = ctl_in_q;
  assign data_c[0] = data_in_q;

  for (genvar g = 0; g < RoundCount; g++) begin : g_cell
    mmb_round_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .enc_shift_i (2'(g)),
      .dec_shift_i (2'(RoundCount - 1 - g)),
      .key_i       (key_q),
      .ctl_i       (ctl_c[g]),
      .data_i      (data_c[g]),
      .ctl_o       (ctl_c[g+1]),
      .data_o      (data_c[g+1])
    );
  end

  assign out_d = ctl_c[RoundCount].mode ? data_c[RoundCount] :
                 key_mix(data_c[RoundCount], key_q, 2'(FinalShift));

  assign out_valid_o = ctl_out_q.valid;
  assign out_word0_o = data_out_q[0];
  assign out_word1_o = data_out_q[1];
  assign out_word2_o = data_out_q[2];
  assign out_word3_o = data_out_q[3];

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("stall without held result");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(data_out_q)))
    else $error("held result changed");
  a_cell_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ctl_c[RoundCount])) else $error("chain moved while frozen");
endmodule
`default_nettype wire

>>> bench/mmb_block_cipher_core_test.sv
// Self-checking bench for mmb_block_cipher_core: directed table plus random blocks,
// checked against a behavioral cipher with random valid/stall gaps and key changes.
// Depends on mmb_pkg and the core RTL.
`timescale 1ns / 1ps
module mmb_block_cipher_core_test;
  import mmb_pkg::*;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = MODE_ENC;
  logic [31:0] in_word0_i = '0, in_word1_i = '0, in_word2_i = '0, in_word3_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_word0_o, out_word1_o, out_word2_o, out_word3_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = KEY_WORD0;
  logic [31:0] cfg_data_i = '0;

  mmb_block_cipher_core DUT (.*);

  always #4 clk_i = ~clk_i;

  logic [31:0] key_q [4];
  block_t      expected_blocks [$];
  bit          failed = 1'b0;
  bit          no_gaps = 1'b0;
  int          stall_left = 0;

  // Multiply mod 2^32-1; an all-ones word passes through.
  function automatic logic [31:0] mulmod_word(logic [31:0] w, logic [31:0] c);
    longint unsigned p;
    if (w == ALL_ONES) return w;
    p = longint'(w) * longint'(c);
    return 32'(p % 64'hFFFF_FFFF);
  endfunction

  function automatic block_t add_key(block_t w, int shift);
    block_t r;
    for (int i = 0; i < 4; i++) r[i] = w[i] ^ key_q[(i + shift) & 3];
    return r;
  endfunction

  function automatic block_t gamma_eta(block_t w, logic inv);
    block_t r;
    logic [31:0] fwd [4] = '{32'h025F_1CDB, 32'h04BE_39B6, 32'h12F8_E6D8, 32'h2F8E_6D81};
    logic [31:0] bwd [4] = '{32'h0DAD_4694, 32'h06D6_A34A, 32'h81B5_A8D2, 32'h281B_5A8D};
    r = w;
    // decrypt undoes delta before the inverse multiply
    if (inv) begin
      if (r[0][0]) r[0] ^= 32'h2AAA_AAAA;
      if (r[3][0]) r[3] ^= 32'h2AAA_AAAA;
    end
    for (int i = 0; i < 4; i++) r[i] = mulmod_word(r[i], inv ? bwd[i] : fwd[i]);
    if (!inv) begin
      if (r[0][0]) r[0] ^= 32'h2AAA_AAAA;
      if (r[3][0]) r[3] ^= 32'h2AAA_AAAA;
    end
    return r;
  endfunction

  function automatic block_t theta(block_t w);
    block_t r;
    r[0] = w[0] ^ w[1] ^ w[3];
    r[1] = w[0] ^ w[1] ^ w[2];
    r[2] = w[1] ^ w[2] ^ w[3];
    r[3] = w[0] ^ w[2] ^ w[3];
    return r;
  endfunction

  function automatic block_t cipher_block(logic mode, block_t w);
    block_t r;
    r = w;
    if (mode == MODE_ENC) begin
      for (int j = 0; j < 6; j++) r = theta(gamma_eta(add_key(r, j), 1'b0));
      r = add_key(r, 6);
    end else begin
      r = add_key(r, 6);
      for (int j = 5; j >= 0; j--) r = add_key(gamma_eta(theta(r), 1'b1), j);
    end
    return r;
  endfunction

  task automatic write_key(key_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    key_q[idx] = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic load_key(logic [31:0] k0, logic [31:0] k1, logic [31:0] k2, logic [31:0] k3);
    wait_drained();
    write_key(KEY_WORD0, k0);
    write_key(KEY_WORD1, k1);
    write_key(KEY_WORD2, k2);
    write_key(KEY_WORD3, k3);
  endtask

  // Typed expectation is used when known is set, else the behavioral cipher.
  task automatic send_block(logic mode, block_t w, bit known = 1'b0, block_t typed = '0);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    in_word0_i <= w[0];
    in_word1_i <= w[1];
    in_word2_i <= w[2];
    in_word3_i <= w[3];
    do @(posedge clk_i); while (in_stall_o);
    expected_blocks.push_back(known ? typed : cipher_block(mode, w));
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      2: return 32'(1) << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Receiver stall pattern, redrawn after each output transfer.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    block_t exp_blk;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left = no_gaps ? 0 : $urandom_range(0, 6);
      if (expected_blocks.size() == 0) begin
        $error("unexpected output block %h %h %h %h",
               out_word0_o, out_word1_o, out_word2_o, out_word3_o);
        failed = 1'b1;
      end else begin
        exp_blk = expected_blocks.pop_front();
        if (out_word0_o !== exp_blk[0]) begin
          $error("out_word0 expected %h got %h", exp_blk[0], out_word0_o);
          failed = 1'b1;
        end
        if (out_word1_o !== exp_blk[1]) begin
          $error("out_word1 expected %h got %h", exp_blk[1], out_word1_o);
          failed = 1'b1;
        end
        if (out_word2_o !== exp_blk[2]) begin
          $error("out_word2 expected %h got %h", exp_blk[2], out_word2_o);
          failed = 1'b1;
        end
        if (out_word3_o !== exp_blk[3]) begin
          $error("out_word3 expected %h got %h", exp_blk[3], out_word3_o);
          failed = 1'b1;
        end
      end
    end
  end

  typedef struct {
    logic   mode;
    block_t blk;
    bit     known;
    block_t typed;
  } vector_t;

  vector_t vectors [] = '{
    '{MODE_ENC, '{0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
    '{MODE_DEC, '{0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
    '{MODE_ENC, '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b0, '0},
    '{MODE_DEC, '{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES}, 1'b0, '0},
    '{MODE_ENC, '{ALL_ONES, 0, ALL_ONES, 0}, 1'b0, '0},
    '{MODE_DEC, '{0, ALL_ONES, 0, ALL_ONES}, 1'b0, '0},
    '{MODE_ENC, '{32'h0000_0001, 0, 0, 32'h0000_0001}, 1'b0, '0},
    '{MODE_DEC, '{32'h0000_0001, 0, 0, 32'h0000_0001}, 1'b0, '0},
    '{MODE_ENC, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
    '{MODE_ENC, '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0},
    '{MODE_DEC, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
    '{MODE_ENC, '{32'hFFFF_FFFE, 32'h0000_0001, 32'h7FFF_FFFF, 32'h2AAA_AAAA}, 1'b0, '0},
    '{MODE_DEC, '{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210}, 1'b0, '0},
    '{MODE_ENC, '{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210}, 1'b0, '0}
  };

  initial begin
    #5ms;
    $display("mmb_block_cipher_core: mismatch");
    $finish;
  end

  initial begin
    for (int i = 0; i < 4; i++) key_q[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset key of zero first, then all-ones key
    foreach (vectors[i]) send_block(vectors[i].mode, vectors[i].blk,
                                    vectors[i].known, vectors[i].typed);
    idle_input();
    load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    for (int i = 2; i < vectors.size(); i++) send_block(vectors[i].mode, vectors[i].blk);

    for (int ph = 0; ph < 7; ph++) begin
      idle_input();
      case (ph)
        0: load_key(32'h0000_0001, 32'h8000_0000, ALL_ONES, '0);
        1: load_key('0, '0, '0, '0);
        default: load_key($urandom, $urandom, $urandom, $urandom);
      endcase
      no_gaps = (ph == 3);
      for (int n = 0; n < 150; n++) begin
        if (ph == 4 && n == 75) begin
          idle_input();
          while (expected_blocks.size() != 0) @(posedge clk_i);
        end
        send_block(1'($urandom_range(0, 1)),
                   '{pick_word(), pick_word(), pick_word(), pick_word()});
      end
      no_gaps = 1'b0;
    end
    idle_input();
    wait_drained();

    if (!failed)
      $display("mmb_block_cipher_core: match");
    else
      $display("mmb_block_cipher_core: mismatch");
    $finish;
  end
endmodule
